>>> design/nsc_pkg.sv
// Shared types and constants for the nested comment skipper.
package nsc_pkg;

    localparam int unsigned LINE_BITS_DEF  = 24;
    localparam int unsigned COL_BITS_DEF   = 16;
    localparam int unsigned DEPTH_BITS_DEF = 8;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // scan mode, one-hot
    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_LINE    = 4'b0010,
        MODE_BLOCK   = 4'b0100,
        MODE_CLOSING = 4'b1000
    } scan_mode_t;

    typedef enum logic [1:0] {
        CLASS_CODE  = 2'd0,
        CLASS_SPACE = 2'd1,
        CLASS_LINE  = 2'd2,
        CLASS_BLOCK = 2'd3
    } byte_class_t;

    // scanner control state handed between top level and step logic
    typedef struct packed {
        scan_mode_t mode;
        logic       swallow;
        logic       last_cr;
    } scan_ctl_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

>>> design/nested_comment_skipper_top.sv
// Top level of the nested comment skipper: state registers and result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, ch, next_ch, next_valid | in
//  output  | out_valid, out_ready, byte_class, line_no,  | out
//          | col_no, nest_level                          |
//
// One item per cycle: the step logic classifies the accepted byte and updates
// scan state in the same cycle; the result appears in the output register on
// the next cycle. in_ready is high whenever the output register is empty or
// being drained, so a stall on out_ready holds the input side only while a
// result is pending. Reset clears mode, depth and the CR flag and puts line
// and column at 1.
module nested_comment_skipper_top #(
    parameter int unsigned LINE_BITS  = nsc_pkg::LINE_BITS_DEF,
    parameter int unsigned COL_BITS   = nsc_pkg::COL_BITS_DEF,
    parameter int unsigned DEPTH_BITS = nsc_pkg::DEPTH_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            ch,
    input  logic [7:0]            next_ch,
    input  logic                  next_valid,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            byte_class,
    output logic [LINE_BITS-1:0]  line_no,
    output logic [COL_BITS-1:0]   col_no,
    output logic [DEPTH_BITS-1:0] nest_level
);

    // scan state
    nsc_pkg::scan_ctl_t    ctl_reg;
    nsc_pkg::scan_ctl_t    ctl_next;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [DEPTH_BITS-1:0] depth_next;
    logic [LINE_BITS-1:0]  line_reg;
    logic [LINE_BITS-1:0]  line_next;
    logic [COL_BITS-1:0]   col_reg;
    logic [COL_BITS-1:0]   col_next;
    nsc_pkg::byte_class_t  cls;

    // result register
    logic                  out_valid_reg;
    logic [1:0]            class_reg;
    logic [LINE_BITS-1:0]  line_out_reg;
    logic [COL_BITS-1:0]   col_out_reg;
    logic [DEPTH_BITS-1:0] depth_out_reg;

    logic in_take;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    nsc_step #(
        .LINE_BITS  (LINE_BITS),
        .COL_BITS   (COL_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_step (
        .ch         (ch),
        .next_ch    (next_ch),
        .next_valid (next_valid),
        .ctl        (ctl_reg),
        .depth      (depth_reg),
        .line_cnt   (line_reg),
        .col_cnt    (col_reg),
        .ctl_next   (ctl_next),
        .depth_next (depth_next),
        .line_next  (line_next),
        .col_next   (col_next),
        .cls        (cls)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.mode    <= nsc_pkg::MODE_NORMAL;
            ctl_reg.swallow <= 1'b0;
            ctl_reg.last_cr <= 1'b0;
            depth_reg       <= '0;
            line_reg        <= LINE_BITS'(1);
            col_reg         <= COL_BITS'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                ctl_reg   <= ctl_next;
                depth_reg <= depth_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
            end
            if (in_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: line and column are reported before this byte's update
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            class_reg     <= cls;
            line_out_reg  <= line_reg;
            col_out_reg   <= col_reg;
            depth_out_reg <= depth_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_class = class_reg;
    assign line_no    = line_out_reg;
    assign col_no     = col_out_reg;
    assign nest_level = depth_out_reg;

    // line and column never drop below 1
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line counter reached zero");

    a_col_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg != '0)
        else $error("column counter reached zero");

    // inside a block comment the depth is at least one
    a_block_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.mode == nsc_pkg::MODE_BLOCK) |-> (depth_reg != '0))
        else $error("block mode with zero depth");

    // a pending second delimiter byte only exists inside a comment
    a_swallow_mode: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.swallow |-> (ctl_reg.mode != nsc_pkg::MODE_NORMAL))
        else $error("swallow pending in normal mode");

    // every accepted item yields a result next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> out_valid_reg)
        else $error("accepted item produced no result");

endmodule

>>> design/nsc_step.sv
// Per-byte classification and state update for the comment skipper.
module nsc_step #(
    parameter int unsigned LINE_BITS  = nsc_pkg::LINE_BITS_DEF,
    parameter int unsigned COL_BITS   = nsc_pkg::COL_BITS_DEF,
    parameter int unsigned DEPTH_BITS = nsc_pkg::DEPTH_BITS_DEF
) (
    input  logic [7:0]            ch,
    input  logic [7:0]            next_ch,
    input  logic                  next_valid,
    input  nsc_pkg::scan_ctl_t    ctl,
    input  logic [DEPTH_BITS-1:0] depth,
    input  logic [LINE_BITS-1:0]  line_cnt,
    input  logic [COL_BITS-1:0]   col_cnt,
    output nsc_pkg::scan_ctl_t    ctl_next,
    output logic [DEPTH_BITS-1:0] depth_next,
    output logic [LINE_BITS-1:0]  line_next,
    output logic [COL_BITS-1:0]   col_next,
    output nsc_pkg::byte_class_t  cls
);

    logic open_seq;
    logic close_seq;
    logic line_seq;
    logic last_cr_next;
    logic [LINE_BITS-1:0] line_inc;
    logic [COL_BITS-1:0]  col_inc;

    assign open_seq  = next_valid && (ch == nsc_pkg::CH_SLASH) && (next_ch == nsc_pkg::CH_STAR);
    assign close_seq = next_valid && (ch == nsc_pkg::CH_STAR) && (next_ch == nsc_pkg::CH_SLASH);
    assign line_seq  = next_valid && (ch == nsc_pkg::CH_SLASH) && (next_ch == nsc_pkg::CH_SLASH);

    assign line_inc = (line_cnt == '1) ? line_cnt : line_cnt + LINE_BITS'(1);
    assign col_inc  = (col_cnt == '1) ? col_cnt : col_cnt + COL_BITS'(1);

    // mode, depth and class
    always_comb
    begin
        ctl_next.mode    = ctl.mode;
        ctl_next.swallow = 1'b0;
        ctl_next.last_cr = last_cr_next;
        depth_next       = depth;
        cls              = nsc_pkg::CLASS_CODE;
        if (ctl.swallow)
        begin
            case (ctl.mode)
                nsc_pkg::MODE_LINE:    cls = nsc_pkg::CLASS_LINE;
                nsc_pkg::MODE_BLOCK:   cls = nsc_pkg::CLASS_BLOCK;
                nsc_pkg::MODE_CLOSING:
                begin
                    cls           = nsc_pkg::CLASS_BLOCK;
                    ctl_next.mode = nsc_pkg::MODE_NORMAL;
                end
                default:               cls = nsc_pkg::CLASS_CODE;
            endcase
        end
        else
        begin
            case (ctl.mode)
                nsc_pkg::MODE_LINE:
                begin
                    if ((ch == nsc_pkg::CH_CR) || (ch == nsc_pkg::CH_LF))
                    begin
                        cls           = nsc_pkg::CLASS_SPACE;
                        ctl_next.mode = nsc_pkg::MODE_NORMAL;
                    end
                    else
                    begin
                        cls = nsc_pkg::CLASS_LINE;
                    end
                end
                nsc_pkg::MODE_BLOCK:
                begin
                    cls = nsc_pkg::CLASS_BLOCK;
                    if (open_seq)
                    begin
                        if (depth != '1)
                        begin
                            depth_next = depth + DEPTH_BITS'(1);
                        end
                        ctl_next.swallow = 1'b1;
                    end
                    else if (close_seq)
                    begin
                        depth_next = (depth != '0) ? depth - DEPTH_BITS'(1) : depth;
                        if (depth_next == '0)
                        begin
                            ctl_next.mode = nsc_pkg::MODE_CLOSING;
                        end
                        ctl_next.swallow = 1'b1;
                    end
                end
                default:
                begin
                    // normal mode; a closing mode without swallow lands here too
                    ctl_next.mode = nsc_pkg::MODE_NORMAL;
                    if (line_seq)
                    begin
                        cls              = nsc_pkg::CLASS_LINE;
                        ctl_next.mode    = nsc_pkg::MODE_LINE;
                        ctl_next.swallow = 1'b1;
                    end
                    else if (open_seq)
                    begin
                        cls              = nsc_pkg::CLASS_BLOCK;
                        depth_next       = DEPTH_BITS'(1);
                        ctl_next.mode    = nsc_pkg::MODE_BLOCK;
                        ctl_next.swallow = 1'b1;
                    end
                    else if (nsc_pkg::is_space(ch))
                    begin
                        cls = nsc_pkg::CLASS_SPACE;
                    end
                    else
                    begin
                        cls = nsc_pkg::CLASS_CODE;
                    end
                end
            endcase
        end
    end

    // position; CR LF counts once
    always_comb
    begin
        line_next    = line_cnt;
        col_next     = col_cnt;
        last_cr_next = 1'b0;
        if (ch == nsc_pkg::CH_CR)
        begin
            line_next    = line_inc;
            col_next     = COL_BITS'(1);
            last_cr_next = 1'b1;
        end
        else if (ch == nsc_pkg::CH_LF)
        begin
            if (!ctl.last_cr)
            begin
                line_next = line_inc;
                col_next  = COL_BITS'(1);
            end
        end
        else
        begin
            col_next = col_inc;
        end
    end

endmodule
